/* rtl/fpd_pkg.sv */
`timescale 1ns / 1ps
package fpd_pkg;
    localparam int MAX_REGIONS_DEF = 16;
    localparam int MAX_PAGES_DEF   = 64;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int CFG_IDX_W       = 1;

    localparam logic [1:0] OP_ADD_REGION    = 2'd0;
    localparam logic [1:0] OP_LOOKUP        = 2'd1;
    localparam logic [1:0] OP_CLEAR_PAGES   = 2'd2;
    localparam logic [1:0] OP_CLEAR_REGIONS = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MEM_AREA_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PSIZE  = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RSCAN,    // walk region table (add position or lookup match)
        S_RSHIFT,   // open a hole in the region table, one entry at a time
        S_RREAD,    // fetch matched region
        S_DIV,      // restoring divider, one quotient bit a cycle
        S_MUL,      // q * s, one bit a cycle
        S_BASE,     // form page base
        S_DSCAN,    // walk directory
        S_DSHIFT,   // open a hole in the directory
        S_DONE
    } t_state;
endpackage

/* rtl/flash_page_directory.sv */
`timescale 1ns / 1ps
// Flash page directory: a sorted region table (start, page size) and a sorted
// directory of cached pages. One operation is taken at a time; o_ready is low
// while it runs and while the result waits in the output register. Every
// table read is registered: address first, then data. A region add scans up
// to the insert point and shifts the tail one entry at a time. A lookup runs
// a region scan, a region read (skipped with no regions), a restoring
// divide, a shift-add multiply, a step to form the base, a directory scan
// plus, on an allocating insert, a tail shift, and a final step to post the
// result. Tables have one read and one write address each. Clears go straight
// to the done state and post their result from there.
// Tables are not cleared at reset: only entries below the counts are ever read.
module flash_page_directory #(
    parameter int MAX_REGIONS = fpd_pkg::MAX_REGIONS_DEF,
    parameter int MAX_PAGES   = fpd_pkg::MAX_PAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [fpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_address,
    input  logic [31:0]          i_page_size,
    input  logic                 i_allocate,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic                 o_found,
    output logic                 o_added,
    output logic [31:0]          o_page_base,
    output logic [31:0]          o_page_bytes,
    output logic [5:0]           o_page_slot,
    output logic [3:0]           o_region_slot,
    output logic                 o_region_valid,
    output logic                 o_region_exact
);
    localparam int RI_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RC_W = $clog2(MAX_REGIONS + 1);
    localparam int PI_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PC_W = $clog2(MAX_PAGES + 1);
    localparam int AW   = fpd_pkg::ADDR_BITS_DEF;
    localparam int BC_W = $clog2(AW + 1);

    // Tables (one read address and one write address per cycle each)
    logic [AW-1:0] r_reg_start [MAX_REGIONS];
    logic [31:0]   r_reg_psize [MAX_REGIONS];
    logic [AW-1:0] r_dir_base  [MAX_PAGES];
    logic [31:0]   r_dir_size  [MAX_PAGES];

    fpd_pkg::t_state r_state, n_state;

    logic [RC_W-1:0] r_rcnt;
    logic [PC_W-1:0] r_dcnt;
    logic [AW-1:0]   r_mas;
    logic [31:0]     r_dps;

    // Operation latch
    logic [1:0]    r_op;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_x;
    logic [31:0]   r_psz;
    logic          r_alloc;

    // Scan pointers / work registers
    logic [RC_W-1:0] r_ri;     // region scan index
    logic [RC_W-1:0] r_rk;     // region shift index
    logic [RC_W-1:0] r_rm;     // matched region
    logic            r_exact;
    logic [PC_W-1:0] r_di;
    logic [PC_W-1:0] r_dk;
    logic [AW-1:0]   r_st;
    logic [AW-1:0]   r_s;      // page size (fits AW since we zero-extend 32)
    logic            r_below;
    logic            r_bad;
    logic [AW-1:0]   r_n;      // dividend
    logic [AW-1:0]   r_q;
    logic [AW-1:0]   r_rem;
    logic [AW-1:0]   r_prod;
    logic [AW-1:0]   r_mcand;
    logic [BC_W-1:0] r_bc;
    logic [AW-1:0]   r_base;
    logic            r_rd_pend; // table read latency bubble

    // Result register
    logic       r_ovalid;
    logic [1:0] r_status;
    logic       r_found, r_added;
    logic [31:0] r_pbase, r_pbytes;
    logic [5:0] r_pslot;
    logic [3:0] r_rslot;
    logic       r_rvalid, r_rexact;

    logic in_xfer, out_xfer;
    assign o_ready     = (r_state == fpd_pkg::S_IDLE) && !r_ovalid;
    assign in_xfer     = i_valid && o_ready;
    assign out_xfer    = r_ovalid && i_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mas <= '0;
            r_dps <= 32'd65536;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == fpd_pkg::REG_MEM_AREA_START)
                r_mas <= AW'(i_cfg_data);
            else if (i_cfg_index == fpd_pkg::REG_DEFAULT_PSIZE)
                r_dps <= i_cfg_data;
        end
    end

    // Shared units
    logic [AW:0]   div_trial;
    logic [AW-1:0] div_rem_sh;
    assign div_rem_sh = {r_rem[AW-2:0], r_n[AW-1]};
    // shifted remainder keeps its top bit: divisors may use all AW bits
    assign div_trial  = {r_rem, r_n[AW-1]} - {1'b0, r_s};

    // Read ports
    logic [RI_W-1:0] rd_ri;
    logic [PI_W-1:0] rd_di;
    logic [AW-1:0]   rs_q;
    logic [31:0]     rp_q;
    logic [AW-1:0]   db_q;
    logic [31:0]     ds_q;

    always_comb begin
        rd_ri = r_ri[RI_W-1:0];
        if (r_state == fpd_pkg::S_RSHIFT) rd_ri = RI_W'(r_rk - RC_W'(1));
        else if (r_state == fpd_pkg::S_RREAD) rd_ri = r_rm[RI_W-1:0];
        rd_di = r_di[PI_W-1:0];
        if (r_state == fpd_pkg::S_DSHIFT) rd_di = PI_W'(r_dk - PC_W'(1));
    end

    always_ff @(posedge i_clk) begin
        rs_q <= r_reg_start[rd_ri];
        rp_q <= r_reg_psize[rd_ri];
        db_q <= r_dir_base[rd_di];
        ds_q <= r_dir_size[rd_di];
    end

    // Allocating miss with room in the directory
    logic miss_ins;
    assign miss_ins = !r_bad && r_alloc && (r_dcnt < PC_W'(MAX_PAGES));

    // Directory entry just read holds the address
    logic dscan_hit;
    assign dscan_hit = r_rd_pend && !(r_addr < db_q) && ((r_addr - db_q) < AW'(ds_q));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpd_pkg::S_IDLE: if (in_xfer) begin
                unique case (i_op)
                    fpd_pkg::OP_ADD_REGION, fpd_pkg::OP_LOOKUP: n_state = fpd_pkg::S_RSCAN;
                    default: n_state = fpd_pkg::S_DONE;
                endcase
            end
            fpd_pkg::S_RSCAN: begin
                if (r_rd_pend) begin
                    if (r_op == fpd_pkg::OP_ADD_REGION) begin
                        if (rs_q > r_addr) n_state = fpd_pkg::S_RSHIFT;
                    end else if (rs_q > r_x) n_state = fpd_pkg::S_RREAD;
                end else if (r_ri >= r_rcnt) begin
                    n_state = (r_op == fpd_pkg::OP_ADD_REGION) ? fpd_pkg::S_RSHIFT
                                                               : fpd_pkg::S_RREAD;
                end
            end
            fpd_pkg::S_RSHIFT: if (!r_rd_pend && r_rk == r_ri) n_state = fpd_pkg::S_DONE;
            fpd_pkg::S_RREAD: if (r_rd_pend || r_rcnt == '0) n_state = fpd_pkg::S_DIV;
            fpd_pkg::S_DIV: if (r_bc == '0) n_state = fpd_pkg::S_MUL;
            fpd_pkg::S_MUL: if (r_bc == '0) n_state = fpd_pkg::S_BASE;
            fpd_pkg::S_BASE: n_state = fpd_pkg::S_DSCAN;
            fpd_pkg::S_DSCAN: begin
                if (r_rd_pend) begin
                    if (r_addr < db_q)
                        n_state = miss_ins ? fpd_pkg::S_DSHIFT : fpd_pkg::S_DONE;
                    else if (dscan_hit) n_state = fpd_pkg::S_DONE;
                end else if (r_di >= r_dcnt) begin
                    n_state = miss_ins ? fpd_pkg::S_DSHIFT : fpd_pkg::S_DONE;
                end
            end
            fpd_pkg::S_DSHIFT: if (!r_rd_pend && r_dk == r_di) n_state = fpd_pkg::S_DONE;
            fpd_pkg::S_DONE: n_state = fpd_pkg::S_IDLE;
            default: n_state = fpd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= fpd_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt    <= '0;
            r_dcnt    <= '0;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            if (out_xfer) r_ovalid <= 1'b0;
            unique case (r_state)
                fpd_pkg::S_IDLE: if (in_xfer) begin
                    r_op      <= i_op;
                    r_addr    <= AW'(i_address);
                    r_x       <= AW'(i_address) + r_mas;
                    r_psz     <= i_page_size;
                    r_alloc   <= i_allocate;
                    r_rm      <= '0;
                    r_exact   <= 1'b0;
                    r_di      <= '0;
                    r_rd_pend <= 1'b0;
                    r_found   <= 1'b0;
                    r_added   <= 1'b0;
                    r_pbase   <= '0;
                    r_pbytes  <= '0;
                    r_pslot   <= '0;
                    r_rslot   <= '0;
                    r_rvalid  <= 1'b0;
                    r_rexact  <= 1'b0;
                    if (i_op == fpd_pkg::OP_CLEAR_PAGES) r_dcnt <= '0;
                    if (i_op == fpd_pkg::OP_CLEAR_REGIONS) r_rcnt <= '0;
                    if (i_op == fpd_pkg::OP_ADD_REGION && i_page_size == '0) begin
                        r_status <= fpd_pkg::ST_ZERO;
                        r_ri     <= r_rcnt; // skip scan
                    end else if (i_op == fpd_pkg::OP_ADD_REGION
                                 && r_rcnt >= RC_W'(MAX_REGIONS)) begin
                        r_status <= fpd_pkg::ST_FULL;
                        r_ri     <= r_rcnt;
                    end else begin
                        r_status <= fpd_pkg::ST_OK;
                        r_ri     <= '0;
                    end
                end
                fpd_pkg::S_RSCAN: begin
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        if (r_op == fpd_pkg::OP_ADD_REGION) begin
                            if (rs_q > r_addr) r_rk <= r_rcnt;
                            else r_ri <= r_ri + RC_W'(1);
                        end else if (!(rs_q > r_x)) begin
                            r_rm    <= r_ri;
                            r_exact <= 1'b1;
                            r_ri    <= r_ri + RC_W'(1);
                        end
                    end else if (r_ri < r_rcnt) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_rk <= r_rcnt;
                    end
                end
                fpd_pkg::S_RSHIFT: begin
                    if (r_status != fpd_pkg::ST_OK) begin
                        r_rk <= r_ri;
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_reg_start[r_rk[RI_W-1:0]] <= rs_q;
                        r_reg_psize[r_rk[RI_W-1:0]] <= rp_q;
                        r_rk <= r_rk - RC_W'(1);
                    end else if (r_rk != r_ri) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_reg_start[r_ri[RI_W-1:0]] <= r_addr;
                        r_reg_psize[r_ri[RI_W-1:0]] <= r_psz;
                        r_rcnt  <= r_rcnt + RC_W'(1);
                        r_rslot <= 4'(r_ri);
                    end
                end
                fpd_pkg::S_RREAD: begin
                    // no regions: no table read, go straight on
                    r_rd_pend <= (r_rcnt != '0) && !r_rd_pend;
                    r_rslot  <= 4'(r_rm);
                    r_rvalid <= r_rcnt != '0;
                    r_rexact <= r_exact;
                    r_bc     <= BC_W'(AW);
                    r_rem    <= '0;
                    r_q      <= '0;
                    if (r_rcnt == '0) begin
                        r_st    <= '0;
                        r_s     <= AW'(r_dps);
                        r_below <= 1'b0;
                        r_n     <= r_addr;
                        r_bad   <= r_dps == '0;
                    end else begin
                        r_st    <= rs_q;
                        r_s     <= AW'(rp_q);
                        r_below <= r_x < rs_q;
                        r_n     <= (r_x < rs_q) ? rs_q - r_x : r_x - rs_q;
                        r_bad   <= 1'b0;
                    end
                end
                fpd_pkg::S_DIV: begin
                    if (r_bc != '0) begin
                        r_n  <= {r_n[AW-2:0], 1'b0};
                        r_bc <= r_bc - BC_W'(1);
                        if (!r_bad && !div_trial[AW]) begin
                            r_rem <= div_trial[AW-1:0];
                            r_q   <= {r_q[AW-2:0], 1'b1};
                        end else begin
                            r_rem <= div_rem_sh;
                            r_q   <= {r_q[AW-2:0], 1'b0};
                        end
                    end else begin
                        // round up away from the region start when below it
                        r_q     <= r_q + AW'(r_below && r_rem != '0);
                        r_mcand <= r_s;
                        r_prod  <= '0;
                        r_bc    <= BC_W'(AW);
                    end
                end
                fpd_pkg::S_MUL: begin
                    if (r_bc != '0) begin
                        if (r_q[0]) r_prod <= r_prod + r_mcand;
                        r_q     <= r_q >> 1;
                        r_mcand <= r_mcand << 1;
                        r_bc    <= r_bc - BC_W'(1);
                    end
                end
                fpd_pkg::S_BASE: begin
                    if (r_bad) r_base <= '0;
                    else if (r_rcnt == '0) r_base <= r_prod;
                    else if (r_below) r_base <= r_st - r_prod - r_mas;
                    else r_base <= r_st + r_prod - r_mas;
                end
                fpd_pkg::S_DSCAN: begin
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        if (dscan_hit) begin
                            r_found    <= 1'b1;
                            r_pbase    <= 32'(db_q);
                            r_pbytes   <= ds_q;
                        end else if (!(r_addr < db_q)) r_di <= r_di + PC_W'(1);
                    end else if (r_di < r_dcnt) begin
                        r_rd_pend <= 1'b1;
                    end
                    r_dk <= r_dcnt;
                end
                fpd_pkg::S_DSHIFT: begin
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        r_dir_base[r_dk[PI_W-1:0]] <= db_q;
                        r_dir_size[r_dk[PI_W-1:0]] <= ds_q;
                        r_dk <= r_dk - PC_W'(1);
                    end else if (r_dk != r_di) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_dir_base[r_di[PI_W-1:0]] <= r_base;
                        r_dir_size[r_di[PI_W-1:0]] <= 32'(r_s);
                        r_dcnt  <= r_dcnt + PC_W'(1);
                        r_added <= 1'b1;
                    end
                end
                fpd_pkg::S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
            // Directory scan finished: settle miss outcome
            if (r_state == fpd_pkg::S_DSCAN && n_state != fpd_pkg::S_DSCAN) begin
                r_pslot <= 6'(r_di);
                if (!dscan_hit) begin
                    if (r_bad) r_status <= fpd_pkg::ST_ZERO;
                    else begin
                        r_pbase  <= 32'(r_base);
                        r_pbytes <= 32'(r_s);
                        if (r_alloc && r_dcnt >= PC_W'(MAX_PAGES))
                            r_status <= fpd_pkg::ST_FULL;
                    end
                end
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_added        = r_added;
    assign o_page_base    = r_pbase;
    assign o_page_bytes   = r_pbytes;
    assign o_page_slot    = r_pslot;
    assign o_region_slot  = r_rslot;
    assign o_region_valid = r_rvalid;
    assign o_region_exact = r_rexact;

    // Region count never exceeds the table depth.
    a_rcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RC_W'(MAX_REGIONS)) else $error("region count overflow");
    // Directory count never exceeds the table depth.
    a_dcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= PC_W'(MAX_PAGES)) else $error("directory count overflow");
    // No input is taken while a result is held.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !o_ready) else $error("ready with result pending");
endmodule
